[src/sprf_pkg.sv]
// shared types, field widths and codes for the sorted page run finder
// no dependencies; imported by sprf_cell, sorted_page_contiguous_run_finder and the testbench
package sprf_pkg;

    // default sizing
    localparam int CAPACITY_DEF         = 128;
    localparam int PAGE_NUMBER_BITS_DEF = 20;

    // port field widths
    localparam int ACTION_W  = 2;
    localparam int PAGE_W    = 20;
    localparam int STATUS_W  = 3;
    localparam int POS_W     = 7;
    localparam int COUNT_W   = 8;
    localparam int RUN_LEN_W = 8;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_CLEARED  = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FOUND    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NORUN    = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                 insert_en;
        logic [RUN_LEN_W-1:0] run_length;
    } cell_ctl_t;

endpackage

[src/sprf_cell.sv]
// one cell of the sorted page chain: holds one page, shifts on insert,
// and extends the run-search packet that travels one cell per cycle; uses sprf_pkg
module sprf_cell #(
    parameter int INDEX     = 0,
    parameter int PAGE_BITS = sprf_pkg::PAGE_NUMBER_BITS_DEF,
    parameter int CNT_W     = $clog2(sprf_pkg::CAPACITY_DEF + 1),
    parameter int IDX_W     = $clog2(sprf_pkg::CAPACITY_DEF)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sprf_pkg::cell_ctl_t   ctl,
    input  logic [CNT_W-1:0]      count,
    input  logic [PAGE_BITS-1:0]  ins_page,
    input  logic [PAGE_BITS-1:0]  left_page,
    input  logic                  left_gt,
    output logic [PAGE_BITS-1:0]  page,
    output logic                  gt,
    input  logic                  scan_found_in,
    input  logic [CNT_W-1:0]      scan_len_in,
    input  logic [IDX_W-1:0]      scan_start_in,
    input  logic [PAGE_BITS-1:0]  scan_page_in,
    output logic                  scan_found_out,
    output logic [CNT_W-1:0]      scan_len_out,
    output logic [IDX_W-1:0]      scan_start_out,
    output logic [PAGE_BITS-1:0]  scan_page_out
);
    import sprf_pkg::*;

    localparam int               CMP_W    = (CNT_W > RUN_LEN_W) ? CNT_W : RUN_LEN_W;
    localparam logic [CNT_W-1:0] MY_CNT   = CNT_W'(INDEX);
    localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(INDEX);
    localparam bit               HAS_LEFT = (INDEX > 0);

    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic                 found_reg, found_next;
    logic [CNT_W-1:0]     len_reg, len_next;
    logic [IDX_W-1:0]     start_reg, start_next;
    logic [PAGE_BITS-1:0] spage_reg, spage_next;

    logic                 occupied;
    logic                 at_end;
    logic                 adj;
    logic [PAGE_BITS:0]   left_succ;

    assign occupied  = (MY_CNT < count);
    assign at_end    = (MY_CNT == count);
    assign gt        = occupied && (page_reg > ins_page);
    assign page      = page_reg;
    // left neighbor plus one, no wrap past the top page
    assign left_succ = {1'b0, left_page} + {{PAGE_BITS{1'b0}}, 1'b1};
    assign adj       = HAS_LEFT && (left_succ == {1'b0, page_reg});

    // sorted insert: larger entries move right, the new page lands at the gap
    always_comb
    begin
        page_next = page_reg;
        if (ctl.insert_en)
        begin
            if (left_gt)
                page_next = left_page;
            else if (gt || at_end)
                page_next = ins_page;
        end
    end

    // run search step
    always_comb
    begin
        found_next = scan_found_in;
        len_next   = scan_len_in;
        start_next = scan_start_in;
        spage_next = scan_page_in;
        if (!scan_found_in && occupied)
        begin
            if (adj)
            begin
                len_next = scan_len_in + CNT_W'(1);
            end
            else
            begin
                len_next   = CNT_W'(1);
                start_next = MY_IDX;
                spage_next = page_reg;
            end
            found_next = (CMP_W'(len_next) >= CMP_W'(ctl.run_length));
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg  <= page_next;
        len_reg   <= len_next;
        start_reg <= start_next;
        spage_reg <= spage_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            found_reg <= 1'b0;
        else
            found_reg <= found_next;
    end

    assign scan_found_out = found_reg;
    assign scan_len_out   = len_reg;
    assign scan_start_out = start_reg;
    assign scan_page_out  = spage_reg;

endmodule

[src/sorted_page_contiguous_run_finder.sv]
// top level of the sorted page run finder: controller, result register and
// the chain of sprf_cell instances; uses sprf_pkg
//
// usage
// - request channel (req_valid/req_ready) carries action and page_number;
//   clear empties the table, insert adds a page in sorted order, find looks
//   for the earliest run of run_length pages that each step up by one
// - response channel (rsp_valid/rsp_ready) returns one transaction per request:
//   status, run_position, run_first_page and stored_count
// - run_length is written through cfg_wr_en/cfg_wr_data; the user must write it
//   only while idle, the block itself does not enforce this
// - clear and insert go straight to the result stage; rsp_valid rises when the
//   response register is free and loaded, and the next request can then be taken
// - find sends a search packet down the chain, one cell per cycle; once it has
//   reached the end, the result moves to the result stage as for clear and insert
// - one request is in flight at a time; a new request is taken only once the
//   previous result has been loaded into the response register, which waits
//   while a response is stalled by the receiver; a stalled response holds its payload
// - reset empties the table and clears run_length; page storage itself is
//   not cleared, entries past the stored count are never looked at
module sorted_page_contiguous_run_finder #(
    parameter int CAPACITY         = sprf_pkg::CAPACITY_DEF,
    parameter int PAGE_NUMBER_BITS = sprf_pkg::PAGE_NUMBER_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [sprf_pkg::RUN_LEN_W-1:0]    cfg_wr_data,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  logic [sprf_pkg::ACTION_W-1:0]     action,
    input  logic [sprf_pkg::PAGE_W-1:0]       page_number,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output logic [sprf_pkg::STATUS_W-1:0]     status,
    output logic [sprf_pkg::POS_W-1:0]        run_position,
    output logic [sprf_pkg::PAGE_W-1:0]       run_first_page,
    output logic [sprf_pkg::COUNT_W-1:0]      stored_count
);
    import sprf_pkg::*;

    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int PB        = PAGE_NUMBER_BITS;
    localparam int PEXT_W    = (PB > PAGE_W) ? PB : PAGE_W;
    localparam int POSEXT_W  = (IDX_W > POS_W) ? IDX_W : POS_W;
    localparam int CNTEXT_W  = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    // control state
    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [RUN_LEN_W-1:0] run_length_reg;
    logic [CNT_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    // pending result
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [IDX_W-1:0]     res_pos_reg, res_pos_next;
    logic [PB-1:0]        res_page_reg, res_page_next;

    // response register
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [PAGE_W-1:0]    first_reg, first_next;
    logic [COUNT_W-1:0]   stored_reg, stored_next;

    logic                 req_accept;
    logic                 rsp_load;
    cell_ctl_t            ctl;
    logic [PEXT_W-1:0]    page_in_ext;
    logic [PB-1:0]        ins_page;
    logic [PEXT_W-1:0]    page_out_ext;
    logic [POSEXT_W-1:0]  pos_out_ext;
    logic [CNTEXT_W-1:0]  cnt_out_ext;

    // chain links, one entry per cell
    logic [PB-1:0]        cell_page  [CAPACITY];
    logic                 cell_gt    [CAPACITY];
    logic [PB-1:0]        left_page  [CAPACITY];
    logic                 left_gt    [CAPACITY];
    logic                 sc_found   [CAPACITY];
    logic [CNT_W-1:0]     sc_len     [CAPACITY];
    logic [IDX_W-1:0]     sc_start   [CAPACITY];
    logic [PB-1:0]        sc_page    [CAPACITY];
    logic                 sc_found_l [CAPACITY];
    logic [CNT_W-1:0]     sc_len_l   [CAPACITY];
    logic [IDX_W-1:0]     sc_start_l [CAPACITY];
    logic [PB-1:0]        sc_page_l  [CAPACITY];

    // page kept to PAGE_NUMBER_BITS bits
    assign page_in_ext  = PEXT_W'(page_number);
    assign ins_page     = page_in_ext[PB-1:0];

    assign req_ready    = (state_reg == ST_IDLE);
    assign req_accept   = req_valid && req_ready;

    // widen or trim results to the port widths
    assign page_out_ext = PEXT_W'(res_page_reg);
    assign pos_out_ext  = POSEXT_W'(res_pos_reg);
    assign cnt_out_ext  = CNTEXT_W'(count_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        scan_cnt_next   = scan_cnt_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_page_next   = res_page_reg;
        ctl.insert_en   = 1'b0;
        ctl.run_length  = run_length_reg;
        rsp_load        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    res_pos_next  = '0;
                    res_page_next = '0;
                    state_next    = ST_DONE;
                    case (action)
                        ACT_CLEAR:
                        begin
                            count_next      = '0;
                            res_status_next = STAT_CLEARED;
                        end
                        ACT_INSERT:
                        begin
                            if (count_reg < CAP_CNT)
                            begin
                                ctl.insert_en   = 1'b1;
                                count_next      = count_reg + CNT_W'(1);
                                res_status_next = STAT_INSERTED;
                            end
                            else
                            begin
                                res_status_next = STAT_FULL;
                            end
                        end
                        ACT_FIND:
                        begin
                            scan_cnt_next = '0;
                            state_next    = ST_SCAN;
                        end
                        default:
                        begin
                            res_status_next = STAT_NORUN;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                scan_cnt_next = scan_cnt_reg + CNT_W'(1);
                // packet has reached the end of the chain
                if (scan_cnt_reg == CAP_CNT)
                begin
                    state_next = ST_DONE;
                    if (sc_found[CAPACITY-1] && (run_length_reg != '0))
                    begin
                        res_status_next = STAT_FOUND;
                        res_pos_next    = sc_start[CAPACITY-1];
                        res_page_next   = sc_page[CAPACITY-1];
                    end
                    else
                    begin
                        res_status_next = STAT_NORUN;
                        res_pos_next    = '0;
                        res_page_next   = '0;
                    end
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // response register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        status_next    = status_reg;
        pos_next       = pos_reg;
        first_next     = first_reg;
        stored_next    = stored_reg;
        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
            status_next    = res_status_reg;
            pos_next       = pos_out_ext[POS_W-1:0];
            first_next     = page_out_ext[PAGE_W-1:0];
            stored_next    = cnt_out_ext[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            run_length_reg <= '0;
            scan_cnt_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_cnt_reg  <= scan_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
                run_length_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_page_reg   <= res_page_next;
        status_reg     <= status_next;
        pos_reg        <= pos_next;
        first_reg      <= first_next;
        stored_reg     <= stored_next;
    end

    assign rsp_valid      = rsp_valid_reg;
    assign status         = status_reg;
    assign run_position   = pos_reg;
    assign run_first_page = first_reg;
    assign stored_count   = stored_reg;

    // chain of cells; cell 0 has no left neighbor and starts a fresh packet
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            assign left_page[i]  = '0;
            assign left_gt[i]    = 1'b0;
            assign sc_found_l[i] = 1'b0;
            assign sc_len_l[i]   = '0;
            assign sc_start_l[i] = '0;
            assign sc_page_l[i]  = '0;
        end
        else
        begin : g_link
            assign left_page[i]  = cell_page[i-1];
            assign left_gt[i]    = cell_gt[i-1];
            assign sc_found_l[i] = sc_found[i-1];
            assign sc_len_l[i]   = sc_len[i-1];
            assign sc_start_l[i] = sc_start[i-1];
            assign sc_page_l[i]  = sc_page[i-1];
        end

        sprf_cell #(
            .INDEX     (i),
            .PAGE_BITS (PB),
            .CNT_W     (CNT_W),
            .IDX_W     (IDX_W)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .ctl            (ctl),
            .count          (count_reg),
            .ins_page       (ins_page),
            .left_page      (left_page[i]),
            .left_gt        (left_gt[i]),
            .page           (cell_page[i]),
            .gt             (cell_gt[i]),
            .scan_found_in  (sc_found_l[i]),
            .scan_len_in    (sc_len_l[i]),
            .scan_start_in  (sc_start_l[i]),
            .scan_page_in   (sc_page_l[i]),
            .scan_found_out (sc_found[i]),
            .scan_len_out   (sc_len[i]),
            .scan_start_out (sc_start[i]),
            .scan_page_out  (sc_page[i])
        );
    end

    // table never holds more than its capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("stored count above capacity");

    // an insert into a table with room grows it by exactly one
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && (action == ACT_INSERT) && (count_reg < CAP_CNT))
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the table");

    // a find always walks the chain before answering
    a_find_scans: assert property (@(posedge clk) disable iff (!rst_n)
        (req_accept && (action == ACT_FIND)) |=> (state_reg == ST_SCAN))
        else $error("find skipped the chain scan");

    // responses are only launched from the result stage
    a_rsp_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("response raised outside the result stage");

    // a non-found answer carries no position or page
    a_nofind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && (status_reg != STAT_FOUND))
        |-> ((pos_reg == '0) && (first_reg == '0)))
        else $error("position or page set on a non-found response");

endmodule

[bench/testbench.sv]
// testbench for sorted_page_contiguous_run_finder: sorted inserts, clears and run searches
// checked against a cycle-free table predictor kept in this file
// depends on sprf_pkg and the sorted_page_contiguous_run_finder rtl only
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sprf_pkg::*;

    localparam int CAPACITY = CAPACITY_DEF;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [PAGE_W-1:0] PAGE_MAX = {PAGE_W{1'b1}};
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_REPORTS = 10;

    // one response transaction as the block presents it
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
        logic [PAGE_W-1:0]   first_page;
        logic [COUNT_W-1:0]  count;
    } page_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [RUN_LEN_W-1:0] cfg_wr_data;
    logic                 req_valid;
    logic                 req_ready;
    logic [ACTION_W-1:0]  action;
    logic [PAGE_W-1:0]    page_number;
    logic                 rsp_valid;
    logic                 rsp_ready;
    logic [STATUS_W-1:0]  status;
    logic [POS_W-1:0]     run_position;
    logic [PAGE_W-1:0]    run_first_page;
    logic [COUNT_W-1:0]   stored_count;

    sorted_page_contiguous_run_finder u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .action         (action),
        .page_number    (page_number),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .status         (status),
        .run_position   (run_position),
        .run_first_page (run_first_page),
        .stored_count   (stored_count)
    );

    // predictor state: our own copy of the sorted table and the run length
    logic [PAGE_W-1:0]    page_store [CAPACITY];
    int                   page_total;
    logic [RUN_LEN_W-1:0] run_len_model;

    // responses still owed by the block, oldest first
    page_result_t         pending_results [$];

    // idle percentages for both sides, and the long receiver hold-off
    int                   send_idle_pct;
    int                   rsp_idle_pct;
    int                   rsp_hold_cycles;

    int                   mismatch_count;
    int unsigned          cycle_count;
    logic [PAGE_W-1:0]    cluster_base;
    page_result_t         want_rsp;

    // free-running clock, 2 ns period
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // work out the response to one request and update the table copy
    function automatic page_result_t apply_page_request(
        input logic [ACTION_W-1:0] act,
        input logic [PAGE_W-1:0]   page
    );
        page_result_t r;
        int           slot;
        int           k;
        int           i;
        int           start;
        int           len;
        bit           hit;
        r = '0;
        r.status = STAT_NORUN;
        case (act)
            ACT_CLEAR:
            begin
                page_total = 0;
                r.status = STAT_CLEARED;
            end
            ACT_INSERT:
            begin
                if (page_total >= CAPACITY)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    // new page goes after every equal entry
                    slot = 0;
                    while (slot < page_total && page_store[slot] <= page)
                        slot++;
                    for (k = page_total; k > slot; k--)
                        page_store[k] = page_store[k-1];
                    page_store[slot] = page;
                    page_total++;
                    r.status = STAT_INSERTED;
                end
            end
            ACT_FIND:
            begin
                hit = 1'b0;
                start = 0;
                if (run_len_model != 0 && run_len_model <= page_total)
                begin
                    if (run_len_model == 1)
                    begin
                        hit = 1'b1;
                    end
                    else
                    begin
                        len = 1;
                        for (i = 1; i < page_total && !hit; i++)
                        begin
                            // one extra bit so the top page has no successor
                            if ({1'b0, page_store[i]} == {1'b0, page_store[i-1]} + 1'b1)
                            begin
                                len++;
                            end
                            else
                            begin
                                start = i;
                                len = 1;
                            end
                            if (len >= run_len_model)
                                hit = 1'b1;
                        end
                    end
                end
                if (hit)
                begin
                    r.status = STAT_FOUND;
                    r.position = start[POS_W-1:0];
                    r.first_page = page_store[start];
                end
            end
            default: ;  // unused action code leaves the table alone
        endcase
        r.count = page_total[COUNT_W-1:0];
        return r;
    endfunction

    // log a failure; only the first few get a printed line
    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, got);
    endtask

    // response monitor: every accepted transaction is matched to the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
            begin
                note_mismatch("unexpected response status", '0, {29'd0, status});
            end
            else
            begin
                want_rsp = pending_results.pop_front();
                if (status !== want_rsp.status)
                    note_mismatch("status", 32'(want_rsp.status), 32'(status));
                if (run_position !== want_rsp.position)
                    note_mismatch("run_position", 32'(want_rsp.position),
                                  32'(run_position));
                if (run_first_page !== want_rsp.first_page)
                    note_mismatch("run_first_page", 32'(want_rsp.first_page),
                                  32'(run_first_page));
                if (stored_count !== want_rsp.count)
                    note_mismatch("stored_count", 32'(want_rsp.count), 32'(stored_count));
            end
        end
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("sorted_page_contiguous_run_finder verification failed");
            $finish;
        end
    end

    // receiver: random stalls, or a counted hold-off when one is requested
    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold_cycles > 0)
            begin
                rsp_ready <= 1'b0;
                rsp_hold_cycles--;
            end
            else
            begin
                rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
            end
        end
    end

    // offer one request transaction; entered and left at a falling edge
    task automatic send_request(input logic [ACTION_W-1:0] act,
                                input logic [PAGE_W-1:0]   page);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid   <= 1'b1;
        action      <= act;
        page_number <= page;
        // wait for the handshake, sampled at the rising edge
        do
            @(posedge clk);
        while (!req_ready);
        pending_results.push_back(apply_page_request(act, page));
        @(negedge clk);
    endtask

    // stop offering and wait until every owed response has come back
    task automatic drain_requests();
        req_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // run_length may only change while the block is idle
    task automatic set_run_length(input logic [RUN_LEN_W-1:0] len);
        drain_requests();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= len;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        run_len_model = len;
    endtask

    // nothing stored and run_length still at its reset value
    task automatic test_empty_table();
        send_request(ACT_FIND, '0);
        send_request(ACT_UNUSED, PAGE_MAX);
        send_request(ACT_CLEAR, '0);
        send_request(ACT_FIND, PAGE_MAX);
    endtask

    // sorted placement, duplicates after equal entries, duplicates break a run
    task automatic test_sorted_insert();
        set_run_length(8'd2);
        send_request(ACT_CLEAR, '0);
        send_request(ACT_INSERT, 20'd5);
        send_request(ACT_INSERT, 20'd3);
        send_request(ACT_INSERT, 20'd5);
        send_request(ACT_INSERT, 20'd4);
        send_request(ACT_INSERT, PAGE_MAX);
        send_request(ACT_INSERT, '0);
        send_request(ACT_FIND, '0);
        set_run_length(8'd4);
        send_request(ACT_FIND, '0);
        send_request(ACT_UNUSED, 20'h5a5a5);
    endtask

    // no wrap-around past the top page
    task automatic test_top_page();
        set_run_length(8'd2);
        send_request(ACT_CLEAR, '0);
        send_request(ACT_INSERT, PAGE_MAX);
        send_request(ACT_INSERT, '0);
        send_request(ACT_FIND, '0);
        send_request(ACT_INSERT, PAGE_MAX - 1'b1);
        send_request(ACT_FIND, '0);
    endtask

    // run of one matches at once; a run longer than the table never does
    task automatic test_short_and_long_runs();
        set_run_length(8'd1);
        send_request(ACT_FIND, '0);
        send_request(ACT_CLEAR, '0);
        send_request(ACT_FIND, '0);
        set_run_length(8'd128);
        send_request(ACT_INSERT, 20'd1);
        send_request(ACT_INSERT, 20'd2);
        send_request(ACT_FIND, '0);
    endtask

    // fill the table with one long run in descending order, then overflow it
    task automatic test_full_table();
        logic [PAGE_W-1:0] base;
        int                n;
        set_run_length(8'd128);
        send_request(ACT_CLEAR, '0);
        base = PAGE_W'($urandom_range(0, PAGE_MAX - CAPACITY));
        for (n = CAPACITY - 1; n >= 0; n--)
            send_request(ACT_INSERT, base + n[PAGE_W-1:0]);
        send_request(ACT_FIND, '0);
        send_request(ACT_INSERT, PAGE_W'($urandom()));
        send_request(ACT_UNUSED, '0);
        set_run_length(8'd127);
        send_request(ACT_FIND, '0);
        send_request(ACT_CLEAR, '0);
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_response_backpressure();
        int saved_idle;
        int n;
        set_run_length(8'd3);
        saved_idle = send_idle_pct;
        send_idle_pct = 0;
        rsp_hold_cycles = 300;
        for (n = 0; n < 12; n++)
            send_request((n % 4 == 3) ? ACT_FIND : ACT_INSERT, 20'h40000 + n[PAGE_W-1:0]);
        send_idle_pct = saved_idle;
    endtask

    // one batch of random traffic, mostly inserts clustered so that runs form
    task automatic run_random_batch(input int items, input int clear_pct);
        int                  n;
        int                  pick;
        int                  sel;
        logic [ACTION_W-1:0] act;
        logic [PAGE_W-1:0]   page;
        for (n = 0; n < items; n++)
        begin
            pick = $urandom_range(0, 99);
            sel  = $urandom_range(0, 9);
            if (pick < clear_pct)
                act = ACT_CLEAR;
            else if (pick < clear_pct + 3)
                act = ACT_UNUSED;
            else if (pick < 64)
                act = ACT_INSERT;
            else
                act = ACT_FIND;
            // page choice: near the cluster, near either end, or anywhere
            if (sel < 7)
                page = cluster_base + PAGE_W'($urandom_range(0, 12));
            else if (sel == 7)
                page = PAGE_MAX - PAGE_W'($urandom_range(0, 3));
            else if (sel == 8)
                page = PAGE_W'($urandom_range(0, 3));
            else
                page = PAGE_W'($urandom());
            send_request(act, page);
            if (act == ACT_CLEAR || $urandom_range(0, 49) == 0)
                cluster_base = PAGE_W'($urandom_range(0, PAGE_MAX - 16));
        end
    endtask

    // three idling profiles, several run_length settings in each
    task automatic test_random_traffic();
        int                   mode;
        int                   phase;
        logic [RUN_LEN_W-1:0] len;
        for (mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_idle_pct = 36;
                    rsp_idle_pct  = 50;
                end
                1:
                begin
                    send_idle_pct = 50;
                    rsp_idle_pct  = 36;
                end
                default:
                begin
                    send_idle_pct = 0;
                    rsp_idle_pct  = 0;
                end
            endcase
            for (phase = 0; phase < 6; phase++)
            begin
                case (phase)
                    0: len = RUN_LEN_W'($urandom_range(2, 4));
                    1: len = 8'd1;
                    2: len = RUN_LEN_W'($urandom_range(5, 10));
                    3: len = (mode == 0) ? 8'd0 : 8'd128;
                    4: len = RUN_LEN_W'($urandom_range(0, 128));
                    default: len = 8'd2;
                endcase
                set_run_length(len);
                // every other batch never clears, so the table can fill up
                run_random_batch(57, (phase % 2 == 0) ? 5 : 0);
            end
        end
    endtask

    // main sequence
    initial
    begin
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_wr_data     = '0;
        req_valid       = 1'b0;
        action          = ACT_CLEAR;
        page_number     = '0;
        send_idle_pct   = 36;
        rsp_idle_pct    = 50;
        rsp_hold_cycles = 0;
        mismatch_count  = 0;
        cycle_count     = 0;
        page_total      = 0;
        run_len_model   = '0;
        cluster_base    = PAGE_W'($urandom_range(0, PAGE_MAX - 16));

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_table();
        test_sorted_insert();
        test_top_page();
        test_short_and_long_runs();
        test_full_table();
        test_response_backpressure();
        test_random_traffic();

        // let every owed response arrive, then watch for strays over a full search
        drain_requests();
        repeat (CAPACITY + 8) @(negedge clk);

        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("sorted_page_contiguous_run_finder verification clean");
        else
            $display("sorted_page_contiguous_run_finder verification failed");
        $finish;
    end

endmodule

[files.f]
src/sprf_pkg.sv
src/sprf_cell.sv
src/sorted_page_contiguous_run_finder.sv
bench/testbench.sv
